// ===== rtl/ycc_pkg.sv =====
// ----------------------------------------------------------------------------
// ycc_pkg
// Shared types and constants of the YCbCr to RGB pixel converter.
// ----------------------------------------------------------------------------
package ycc_pkg;

	localparam int FRAC_BITS = 16;
	localparam int PROD_W    = 26;
	localparam int OFF_W     = 9;
	localparam int SUM_W     = 10;

	localparam logic [1:0] MODE_GRAY = 2'd0;
	localparam logic [1:0] MODE_RGB  = 2'd1;
	localparam logic [1:0] MODE_YCC  = 2'd2;

	localparam logic signed [17:0] K_CR_R = 18'sd91881;
	localparam logic signed [17:0] K_CB_B = 18'sd116130;
	localparam logic signed [17:0] K_CR_G = 18'sd46802;
	localparam logic signed [17:0] K_CB_G = 18'sd22553;
	localparam logic signed [PROD_W-1:0] HALF_ONE = PROD_W'(32768);
	localparam logic signed [8:0] CHROMA_BIAS = 9'sd128;

	typedef struct packed {
		logic [7:0] luma_or_first;
		logic [7:0] cb_or_second;
		logic [7:0] cr_or_third;
	} pix_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [1:0] mode;
		pix_t       pix;
	} in_stage_t;

	typedef struct packed {
		logic [1:0]               mode;
		pix_t                     pix;
		logic signed [PROD_W-1:0] p_r;
		logic signed [PROD_W-1:0] p_gb;
		logic signed [PROD_W-1:0] p_gr;
		logic signed [PROD_W-1:0] p_b;
	} prod_stage_t;

	typedef struct packed {
		logic [1:0]              mode;
		pix_t                    pix;
		logic signed [OFF_W-1:0] o_r;
		logic signed [OFF_W-1:0] o_g;
		logic signed [OFF_W-1:0] o_b;
	} offs_stage_t;

endpackage

// ===== rtl/ycc_products.sv =====
// ----------------------------------------------------------------------------
// ycc_products
// Second pipeline stage: removes the chroma bias and forms the four
// coefficient products.
// ----------------------------------------------------------------------------
module ycc_products import ycc_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  in_stage_t   d,
	output prod_stage_t q_s2
);

	logic signed [8:0] cb;
	logic signed [8:0] cr;

	assign cb = $signed({1'b0, d.pix.cb_or_second}) - CHROMA_BIAS;
	assign cr = $signed({1'b0, d.pix.cr_or_third}) - CHROMA_BIAS;

	always_ff @(posedge clk) begin
		if (en) begin
			q_s2.mode <= d.mode;
			q_s2.pix  <= d.pix;
			q_s2.p_r  <= PROD_W'(cr) * PROD_W'(K_CR_R);
			q_s2.p_gb <= PROD_W'(cb) * PROD_W'(K_CB_G);
			q_s2.p_gr <= PROD_W'(cr) * PROD_W'(K_CR_G);
			q_s2.p_b  <= PROD_W'(cb) * PROD_W'(K_CB_B);
		end
	end

endmodule

// ===== rtl/ycc_offsets.sv =====
// ----------------------------------------------------------------------------
// ycc_offsets
// Third pipeline stage: rounds the products and takes the floor of the
// division by 2^16 to get the per-channel offsets.
// ----------------------------------------------------------------------------
module ycc_offsets import ycc_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  prod_stage_t d,
	output offs_stage_t q_s3
);

	logic signed [PROD_W-1:0] sum_r;
	logic signed [PROD_W-1:0] sum_g;
	logic signed [PROD_W-1:0] sum_b;

	assign sum_r = d.p_r + HALF_ONE;
	assign sum_g = HALF_ONE - d.p_gb - d.p_gr;
	assign sum_b = d.p_b + HALF_ONE;

	// The sums stay well inside 25 bits, so the bits above the fraction are
	// the floored quotient.
	always_ff @(posedge clk) begin
		if (en) begin
			q_s3.mode <= d.mode;
			q_s3.pix  <= d.pix;
			q_s3.o_r  <= sum_r[FRAC_BITS+OFF_W-1:FRAC_BITS];
			q_s3.o_g  <= sum_g[FRAC_BITS+OFF_W-1:FRAC_BITS];
			q_s3.o_b  <= sum_b[FRAC_BITS+OFF_W-1:FRAC_BITS];
		end
	end

endmodule

// ===== rtl/ycc_output.sv =====
// ----------------------------------------------------------------------------
// ycc_output
// Last pipeline stage: adds luma, clamps to 0..255 and selects the channels
// for the pixel's color mode.
// ----------------------------------------------------------------------------
module ycc_output import ycc_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  offs_stage_t d,
	output rgb_t        q_s4
);

	logic signed [SUM_W-1:0] luma;
	logic signed [SUM_W-1:0] sum_r;
	logic signed [SUM_W-1:0] sum_g;
	logic signed [SUM_W-1:0] sum_b;
	rgb_t                    conv;
	rgb_t                    sel;

	function automatic logic [7:0] clamp8(input logic signed [SUM_W-1:0] v);
		logic [7:0] r;
		if (v < 0) begin
			r = 8'd0;
		end else if (v > SUM_W'(255)) begin
			r = 8'd255;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

	assign luma  = $signed({{(SUM_W-8){1'b0}}, d.pix.luma_or_first});
	assign sum_r = luma + SUM_W'(d.o_r);
	assign sum_g = luma + SUM_W'(d.o_g);
	assign sum_b = luma + SUM_W'(d.o_b);

	assign conv.red   = clamp8(sum_r);
	assign conv.green = clamp8(sum_g);
	assign conv.blue  = clamp8(sum_b);

	always_comb begin
		case (d.mode)
			MODE_GRAY: begin
				sel.red   = d.pix.luma_or_first;
				sel.green = d.pix.luma_or_first;
				sel.blue  = d.pix.luma_or_first;
			end
			MODE_RGB: begin
				sel.red   = d.pix.luma_or_first;
				sel.green = d.pix.cb_or_second;
				sel.blue  = d.pix.cr_or_third;
			end
			default: begin
				sel = conv;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s4 <= sel;
		end
	end

endmodule

// ===== rtl/ycc_to_rgb_pixel_converter.sv =====
// ----------------------------------------------------------------------------
// ycc_to_rgb_pixel_converter
// Converts one pixel of three 8-bit samples to RGB in gray, RGB passthrough
// or YCbCr mode, with 18-bit fixed-point coefficients of 16 fraction bits.
//
// The input word arrives on pix with pix_valid/pix_ready, and the RGB word
// leaves on rgb with rgb_valid/rgb_ready. Both channels accept a word at a
// clock edge where valid and ready are both high.
// The pipeline has four register stages: input capture, coefficient
// products, rounding and descale, then luma add, clamp and mode select.
// An accepted word is offered on rgb from the last stage, and one
// word is accepted every cycle while the receiver takes words.
// The color mode is written with cfg_we and cfg_wdata and travels with each
// word, so it should only change while the pipeline is empty.
// Reset clears all stage valid bits and sets the mode to YCbCr conversion.
// When the receiver stalls, the stages close up their empty slots and then
// hold; pix_ready goes low only when all four stages hold words.
// ----------------------------------------------------------------------------
module ycc_to_rgb_pixel_converter import ycc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pix_valid,
	output logic       pix_ready,
	input  pix_t       pix,
	output logic       rgb_valid,
	input  logic       rgb_ready,
	output rgb_t       rgb,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata
);

	logic [1:0]  mode_q;
	logic        v_s1;
	logic        v_s2;
	logic        v_s3;
	logic        v_s4;
	logic        adv1;
	logic        adv2;
	logic        adv3;
	logic        adv4;
	in_stage_t   st_s1;
	prod_stage_t st_s2;
	offs_stage_t st_s3;

	assign adv4      = !v_s4 || rgb_ready;
	assign adv3      = !v_s3 || adv4;
	assign adv2      = !v_s2 || adv3;
	assign adv1      = !v_s1 || adv2;
	assign pix_ready = adv1;
	assign rgb_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_YCC;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (adv1) begin
				v_s1 <= pix_valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
			if (adv4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			st_s1.mode <= mode_q;
			st_s1.pix  <= pix;
		end
	end

	ycc_products u_products (
		.clk  (clk),
		.en   (adv2),
		.d    (st_s1),
		.q_s2 (st_s2)
	);

	ycc_offsets u_offsets (
		.clk  (clk),
		.en   (adv3),
		.d    (st_s2),
		.q_s3 (st_s3)
	);

	ycc_output u_output (
		.clk  (clk),
		.en   (adv4),
		.d    (st_s3),
		.q_s4 (rgb)
	);

	a_full_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && v_s3 && v_s4 && !rgb_ready) |-> !pix_ready)
		else $error("Input accepted while the pipeline is full and stalled.");

	a_accept_enters_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid && pix_ready) |=> v_s1)
		else $error("Accepted word did not reach the first stage.");

	a_stall_holds_s3: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && v_s4 && !rgb_ready) |=> v_s3)
		else $error("Third stage word lost during an output stall.");

	a_empty_pipe_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!v_s1 || !v_s2 || !v_s3 || !v_s4 || rgb_ready) |-> pix_ready)
		else $error("Input stalled although a stage slot is free.");

endmodule
